// ===== rtl/core/swte_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding window throughput estimator package
// Shared widths, constants, sequencer states and the divider status type.
// ----------------------------------------------------------------------------
package swte_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 100;

  localparam int unsigned BYTE_W      = 32;
  localparam int unsigned DELAY_W     = 32;
  localparam int unsigned TIME_W      = 48;
  localparam int unsigned EST_W       = 31;
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned PERIOD_US_W = 26;
  localparam int unsigned SUM_W       = 40;
  localparam int unsigned HALF_W      = SUM_W / 2;
  localparam int unsigned SCALE_W     = 23;
  localparam int unsigned PROD_W      = HALF_W + SCALE_W;
  localparam int unsigned DVD_W       = SUM_W + SCALE_W;
  localparam int unsigned QCNT_W      = 5;

  localparam logic [PERIOD_W-1:0]    PERIOD_MIN      = 16'd1000;
  localparam logic [PERIOD_W-1:0]    PERIOD_MAX      = 16'd60000;
  localparam logic [PERIOD_US_W-1:0] US_PER_MS       = 26'd1000;
  localparam logic [PERIOD_US_W-1:0] PERIOD_US_RESET = 26'd5000000;
  localparam logic [SCALE_W-1:0]     SCALE_BPS       = 23'd8000000;
  localparam logic [SCALE_W-1:0]     SCALE_KBPS      = 23'd8000;
  localparam logic [QCNT_W-1:0]      QUOT_STEPS      = 5'd31;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_SUB,
    ST_CHK,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_ADD,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } swte_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/core/swte_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swte_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 100
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/swte_div.sv =====
// ----------------------------------------------------------------------------
// Serial saturating divider
// Restoring division, one quotient bit per cycle, result clipped to 2^31-1.
// ----------------------------------------------------------------------------
module swte_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [swte_pkg::DVD_W-1:0] dividend_i,
  input  logic [swte_pkg::SUM_W-1:0] divisor_i,
  output swte_pkg::div_stat_t        stat_o,
  output logic [swte_pkg::EST_W-1:0] quot_o
);

  import swte_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  dvs_q, dvs_d;
  logic [EST_W-1:0]  low_q, low_d;
  logic [EST_W-1:0]  quot_q, quot_d;

  logic [SUM_W:0]    trial;
  logic [SUM_W:0]    diff;
  logic              ge;
  logic [SUM_W-1:0]  head;

  // If the top bits already reach the divisor the quotient needs 32 bits or more.
  assign head  = SUM_W'(dividend_i[DVD_W-1:EST_W]);
  assign trial = {rem_q, low_q[EST_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    low_d  = low_q;
    quot_d = quot_q;
    if (start_i) begin
      dvs_d = divisor_i;
      if (head >= divisor_i) begin
        quot_d = '1;
        done_d = 1'b1;
      end else begin
        rem_d  = head;
        low_d  = dividend_i[EST_W-1:0];
        cnt_d  = QUOT_STEPS;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d  = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      quot_d = {quot_q[EST_W-2:0], ge};
      low_d  = {low_q[EST_W-2:0], 1'b0};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == QCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    low_q  <= low_d;
    quot_q <= quot_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule

// ===== rtl/core/sliding_window_throughput_estimator_top.sv =====
// ----------------------------------------------------------------------------
// Sliding window throughput estimator
// Ring of recent transfer measurements with live and periodic rate estimates.
// ----------------------------------------------------------------------------
// Usage: each input word carries one transfer measurement (byte count,
// duration in microseconds, current time). It is taken when in_valid_i is
// high and in_stall_o is low; in_stall_o stays high while a word is being
// worked on. Every input word yields exactly one output word, offered on
// out_valid_o and taken when out_stall_i is low.
// Flow: from acceptance to the output word, a word passes the divider once
// when a live estimate is divided out, twice when the periodic kbps latch
// also falls due, and not at all when no division is needed (a saturated
// quotient ends its division early). A new word can be taken in the cycle
// after the output word is loaded, and not before.
// A division that does not saturate runs 31 quotient steps in the serial
// divider, after one shared 20x23 multiplier; there is one division per estimate.
// A finished word sits in the output register; the next input word is taken
// as soon as that word is loaded, even while the receiver stalls. If the
// receiver is still stalling on the previous word, the new one waits in the
// last sequencer step and input stays stalled.
// Reset clears the window, the sums, the sample time, the latched estimate
// and sets the collection period to 5000 ms. The ring memory itself is not
// cleared: an entry is read only after it has been written.
// ----------------------------------------------------------------------------
module sliding_window_throughput_estimator_top #(
  parameter int unsigned WINDOW_DEPTH = swte_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [swte_pkg::PERIOD_W-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [swte_pkg::BYTE_W-1:0]   byte_count_i,
  input  logic [swte_pkg::DELAY_W-1:0]  delay_us_i,
  input  logic [swte_pkg::TIME_W-1:0]   now_us_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          estimate_valid_o,
  output logic [swte_pkg::EST_W-1:0]    estimate_bps_o,
  output logic [swte_pkg::EST_W-1:0]    periodic_kbps_o,
  output logic                          time_zero_o
);

  import swte_pkg::*;

  localparam int unsigned IDX_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned ENT_W = BYTE_W + DELAY_W;

  swte_state_e state_q, state_d;

  // Captured input word.
  logic [BYTE_W-1:0]  bytes_q;
  logic [DELAY_W-1:0] delay_q;
  logic [TIME_W-1:0]  now_q;
  logic               full_q;

  // Window state.
  logic [IDX_W-1:0]       oldest_q;
  logic [CNT_W-1:0]       count_q;
  logic [SUM_W-1:0]       sum_b_q;
  logic [SUM_W-1:0]       sum_t_q;
  logic [TIME_W-1:0]      last_q;
  logic [EST_W-1:0]       latched_q;
  logic [PERIOD_US_W-1:0] period_us_q;

  // Estimate datapath.
  logic               phase_bps_q;
  logic [PROD_W-1:0]  prod_q;
  logic [DVD_W-1:0]   acc_q;
  logic [EST_W-1:0]   bps_q;

  // Output register.
  logic               out_valid_q;
  logic               est_valid_q;
  logic [EST_W-1:0]   est_bps_q;
  logic [EST_W-1:0]   kbps_q;
  logic               tz_q;

  // Sequencer strobes.
  logic ram_we;
  logic div_start;
  logic out_load;

  // Ring memory holds {bytes, delay} of each entry.
  logic [ENT_W-1:0]   ram_rdata;
  logic [IDX_W-1:0]   ram_waddr;
  logic [BYTE_W-1:0]  old_bytes;
  logic [DELAY_W-1:0] old_delay;

  logic [CNT_W:0]     slot_sum;
  logic [CNT_W:0]     slot_wrap;
  logic [IDX_W-1:0]   oldest_inc;

  logic [TIME_W-1:0]  elapsed;
  logic               period_due;
  logic               kbps_due;
  logic               bps_need;
  logic [SCALE_W-1:0] scale;
  logic [HALF_W-1:0]  mul_a;
  logic [PROD_W-1:0]  mul_p;

  div_stat_t          div_stat;
  logic [EST_W-1:0]   div_quot;

  logic [PERIOD_US_W-1:0] cfg_period_us;
  logic                   cfg_ok;

  assign {old_bytes, old_delay} = ram_rdata;

  // Slot for a push into a window that is not yet full: oldest + count, wrapped.
  assign slot_sum   = (CNT_W + 1)'(oldest_q) + (CNT_W + 1)'(count_q);
  assign slot_wrap  = (slot_sum >= (CNT_W + 1)'(WINDOW_DEPTH))
                      ? slot_sum - (CNT_W + 1)'(WINDOW_DEPTH) : slot_sum;
  assign ram_waddr  = full_q ? oldest_q : slot_wrap[IDX_W-1:0];
  assign oldest_inc = (oldest_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : oldest_q + 1'b1;

  // The period counts as elapsed only when the window is full and the clock is not behind the sample time.
  assign elapsed    = now_q - last_q;
  assign period_due = full_q && (now_q >= last_q) &&
                      (elapsed >= TIME_W'(period_us_q));
  assign kbps_due   = period_due && (last_q != '0) && (sum_t_q != '0);
  assign bps_need   = (count_q >= CNT_W'(2)) && (sum_t_q != '0);

  // One shared multiplier: the 40-bit byte sum goes through in two halves.
  assign scale = phase_bps_q ? SCALE_BPS : SCALE_KBPS;
  assign mul_a = (state_q == ST_MUL_HI) ? sum_b_q[SUM_W-1:HALF_W] : sum_b_q[HALF_W-1:0];
  assign mul_p = PROD_W'(mul_a) * PROD_W'(scale);

  assign cfg_period_us = PERIOD_US_W'(cfg_wdata_i) * US_PER_MS;
  assign cfg_ok        = (cfg_wdata_i >= PERIOD_MIN) && (cfg_wdata_i <= PERIOD_MAX);

  swte_ram #(
    .WIDTH (ENT_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({bytes_q, delay_q}),
    .raddr_i (oldest_q),
    .rdata_o (ram_rdata)
  );

  swte_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (sum_t_q),
    .stat_o     (div_stat),
    .quot_o     (div_quot)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_ADD;
      ST_ADD:      state_d = ST_SUB;
      ST_SUB:      state_d = ST_CHK;
      ST_CHK: begin
        if (kbps_due || bps_need) state_d = ST_MUL_LO;
        else                      state_d = ST_DONE;
      end
      ST_MUL_LO:   state_d = ST_MUL_HI;
      ST_MUL_HI:   state_d = ST_MUL_ADD;
      ST_MUL_ADD:  state_d = ST_DIV_GO;
      ST_DIV_GO:   state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          if (!phase_bps_q && bps_need) state_d = ST_MUL_LO;
          else                          state_d = ST_DONE;
        end
      end
      ST_DONE:     if (out_load) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = 1'b1;
    ram_we     = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE:   in_stall_o = 1'b0;
      ST_SUB:    ram_we     = 1'b1;
      ST_DIV_GO: div_start  = 1'b1;
      ST_DONE:   out_load   = !out_valid_q || !out_stall_i;
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Window bookkeeping and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q    <= '0;
      count_q     <= '0;
      sum_b_q     <= '0;
      sum_t_q     <= '0;
      last_q      <= '0;
      latched_q   <= '0;
      period_us_q <= PERIOD_US_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_ok) begin
        period_us_q <= cfg_period_us;
      end
      case (state_q)
        ST_ADD: begin
          sum_b_q <= sum_b_q + SUM_W'(bytes_q);
          sum_t_q <= sum_t_q + SUM_W'(delay_q);
        end
        ST_SUB: begin
          if (full_q) begin
            // The oldest entry leaves the window and its slot takes the new one.
            sum_b_q  <= sum_b_q - SUM_W'(old_bytes);
            sum_t_q  <= sum_t_q - SUM_W'(old_delay);
            oldest_q <= oldest_inc;
          end else begin
            count_q <= count_q + 1'b1;
          end
        end
        ST_CHK: begin
          if (period_due) last_q <= now_q;
        end
        ST_DIV_WAIT: begin
          if (div_stat.done && !phase_bps_q) latched_q <= div_quot;
        end
        default: begin
          latched_q <= latched_q;
        end
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      bytes_q <= byte_count_i;
      delay_q <= delay_us_i;
      now_q   <= now_us_i;
      full_q  <= (count_q == CNT_W'(WINDOW_DEPTH));
    end
    case (state_q)
      ST_CHK: begin
        bps_q       <= '0;
        phase_bps_q <= !kbps_due;
      end
      ST_MUL_LO:  acc_q  <= DVD_W'(mul_p);
      ST_MUL_HI:  prod_q <= mul_p;
      ST_MUL_ADD: acc_q  <= acc_q + {prod_q, {HALF_W{1'b0}}};
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          if (phase_bps_q) bps_q <= div_quot;
          phase_bps_q <= 1'b1;
        end
      end
      default: begin
        bps_q <= bps_q;
      end
    endcase
    if (out_load) begin
      est_valid_q <= (count_q >= CNT_W'(2));
      est_bps_q   <= bps_q;
      kbps_q      <= latched_q;
      tz_q        <= (sum_t_q == '0);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign estimate_valid_o = est_valid_q;
  assign estimate_bps_o   = est_bps_q;
  assign periodic_kbps_o  = kbps_q;
  assign time_zero_o      = tz_q;

`ifndef SYNTHESIS
  // A new output word appears only out of the final sequencer step.
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("output word loaded outside the final step");

  // The window never holds more entries than the ring has slots.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHK |-> count_q <= CNT_W'(WINDOW_DEPTH))
    else $error("entry count beyond window depth");

  // The divider is never started on an empty time total.
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> sum_t_q != '0)
    else $error("division started with zero time total");

  // A zero time total always reports a zero live estimate.
  a_tz_zero_bps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && time_zero_o |-> estimate_bps_o == '0)
    else $error("nonzero estimate with zero time total");

  // The divider is idle whenever the sequencer starts it.
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");
`endif

endmodule
